// ----- hdl/kct_pkg.sv -----
// Shared types, codes and default sizes of the keyed count table.
package kct_pkg;

  localparam int unsigned EntriesPerTable = 16;
  localparam int unsigned Tables          = 4;
  localparam int unsigned KeyBits         = 16;
  localparam int unsigned CountBits       = 16;
  localparam int unsigned FillPortBits    = 5;

  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdClear  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StChanged = 3'd0,
    StNew     = 3'd1,
    StEvicted = 3'd2,
    StNoMatch = 3'd3,
    StFull    = 3'd4
  } status_e;

  // Command token that walks one table's row of cells, one cell per cycle.
  typedef struct packed {
    logic                 active;
    logic                 add;
    logic                 done;
    logic                 evict;
    status_e              status;
    logic [CountBits-1:0] count;
    logic [CountBits-1:0] amount;
  } probe_t;

endpackage

// ----- hdl/kct_cell.sv -----
// One table entry: key, count and valid bit, acting on the passing probe.
module kct_cell import kct_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  probe_t               probe_i,
  input  logic [KEY_BITS-1:0]  probe_key_i,
  input  logic [KEY_BITS-1:0]  nbr_key_i,
  input  logic [CountBits-1:0] nbr_count_i,
  input  logic                 nbr_valid_i,
  output logic [KEY_BITS-1:0]  key_o,
  output logic [CountBits-1:0] count_o,
  output logic                 valid_o,
  output probe_t               probe_o,
  output logic [KEY_BITS-1:0]  probe_key_o
);

  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 valid_q, valid_d;
  probe_t               probe_q, probe_d;
  logic [KEY_BITS-1:0]  probe_key_q;

  always_comb begin
    logic [CountBits:0] sum;
    sum     = {1'b0, count_q} + {1'b0, probe_i.amount};
    key_d   = key_q;
    count_d = count_q;
    valid_d = valid_q;
    probe_d = probe_i;
    if (clr_i) begin
      valid_d = 1'b0;
    end else if (probe_i.active) begin
      if (probe_i.evict) begin
        // close the gap: pull the next entry down
        key_d   = nbr_key_i;
        count_d = nbr_count_i;
        valid_d = nbr_valid_i;
      end else if (!probe_i.done) begin
        if (valid_q && (key_q == probe_key_i)) begin
          probe_d.done = 1'b1;
          if (probe_i.add) begin
            count_d        = sum[CountBits] ? CountMax : sum[CountBits-1:0];
            probe_d.status = StChanged;
            probe_d.count  = count_d;
          end else if (count_q > probe_i.amount) begin
            count_d        = count_q - probe_i.amount;
            probe_d.status = StChanged;
            probe_d.count  = count_d;
          end else begin
            key_d          = nbr_key_i;
            count_d        = nbr_count_i;
            valid_d        = nbr_valid_i;
            probe_d.evict  = 1'b1;
            probe_d.status = StEvicted;
            probe_d.count  = '0;
          end
        end else if (!valid_q && probe_i.add) begin
          // first free slot: append unless the amount is zero
          probe_d.done = 1'b1;
          if (probe_i.amount != '0) begin
            key_d          = probe_key_i;
            count_d        = probe_i.amount;
            valid_d        = 1'b1;
            probe_d.status = StNew;
            probe_d.count  = probe_i.amount;
          end else begin
            probe_d.status = StNoMatch;
            probe_d.count  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else begin
      valid_q <= valid_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    count_q     <= count_d;
    probe_key_q <= probe_key_i;
  end

  assign key_o       = key_q;
  assign count_o     = count_q;
  assign valid_o     = valid_q;
  assign probe_o     = probe_q;
  assign probe_key_o = probe_key_q;

endmodule

// ----- hdl/keyed_count_table_unit.sv -----
// Top level of the keyed count table: rows of entry cells and command control.
// Add, remove and unknown command: a probe crosses the chosen table's row of
//   cells one cell per cycle; the result passes a pending and an output register.
// Clear and out-of-range category skip the row. A new beat is taken only once
//   the last result has moved into the output register.
// Reset empties all tables (valid bits and fill counts); keys and counts are
//   not cleared, and no clearing pass runs.
module keyed_count_table_unit import kct_pkg::*; #(
  parameter int unsigned ENTRIES_PER_TABLE = EntriesPerTable,
  parameter int unsigned TABLES            = Tables,
  parameter int unsigned KEY_BITS          = KeyBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  category_i,
  input  logic [15:0] key_i,
  input  logic [15:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] new_count_o,
  output logic [4:0]  fill_o
);

  localparam int unsigned FillBits = $clog2(ENTRIES_PER_TABLE + 1);
  localparam int unsigned TIdxBits = (TABLES > 1) ? $clog2(TABLES) : 1;

  // Input decode
  logic                 in_accept;
  cmd_e                 cmd;
  logic                 tbl_ok;
  logic [TIdxBits+1:0]  cat_ext;
  logic [TIdxBits-1:0]  tsel;
  logic [KEY_BITS+15:0] key_ext;
  logic [KEY_BITS-1:0]  key_in;
  logic                 clr;

  assign in_accept = in_valid_i && in_ready_o;
  assign cmd       = cmd_e'(cmd_i);
  assign tbl_ok    = (32'(category_i) < TABLES);
  assign cat_ext   = {{TIdxBits{1'b0}}, category_i};
  assign tsel      = cat_ext[TIdxBits-1:0];
  assign key_ext   = {{KEY_BITS{1'b0}}, key_i};
  assign key_in    = key_ext[KEY_BITS-1:0];
  assign clr       = in_accept && (cmd == CmdClear);

  // Control state
  logic                busy_q, busy_d;
  logic [TIdxBits-1:0] cur_t_q;
  probe_t              inj_q [TABLES];
  probe_t              inj_d [TABLES];
  logic [KEY_BITS-1:0] inj_key_q;
  logic [FillBits-1:0] fill_q [TABLES];

  // Pending result, then the output register
  logic                 pend_valid_q, pend_valid_d;
  status_e              pend_status_q, pend_status_d;
  logic [CountBits-1:0] pend_count_q, pend_count_d;
  logic [4:0]           pend_fill_q, pend_fill_d;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [CountBits-1:0] out_count_q;
  logic [4:0]           out_fill_q;
  logic                 out_load;

  // Rows of cells, one row per table
  probe_t               chain_probe [TABLES][ENTRIES_PER_TABLE+1];
  logic [KEY_BITS-1:0]  chain_key   [TABLES][ENTRIES_PER_TABLE+1];
  logic [KEY_BITS-1:0]  cell_key    [TABLES][ENTRIES_PER_TABLE];
  logic [CountBits-1:0] cell_count  [TABLES][ENTRIES_PER_TABLE];
  logic                 cell_valid  [TABLES][ENTRIES_PER_TABLE];

  for (genvar t = 0; t < TABLES; t++) begin : g_table
    assign chain_probe[t][0] = inj_q[t];
    assign chain_key[t][0]   = inj_key_q;
    for (genvar e = 0; e < ENTRIES_PER_TABLE; e++) begin : g_cell
      logic [KEY_BITS-1:0]  nbr_key;
      logic [CountBits-1:0] nbr_count;
      logic                 nbr_valid;
      if (e == ENTRIES_PER_TABLE - 1) begin : g_last
        // past the end of the row: shift in an empty slot
        assign nbr_key   = '0;
        assign nbr_count = '0;
        assign nbr_valid = 1'b0;
      end else begin : g_mid
        assign nbr_key   = cell_key[t][e+1];
        assign nbr_count = cell_count[t][e+1];
        assign nbr_valid = cell_valid[t][e+1];
      end
      kct_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .clr_i      (clr),
        .probe_i    (chain_probe[t][e]),
        .probe_key_i(chain_key[t][e]),
        .nbr_key_i  (nbr_key),
        .nbr_count_i(nbr_count),
        .nbr_valid_i(nbr_valid),
        .key_o      (cell_key[t][e]),
        .count_o    (cell_count[t][e]),
        .valid_o    (cell_valid[t][e]),
        .probe_o    (chain_probe[t][e+1]),
        .probe_key_o(chain_key[t][e+1])
      );
    end
  end

  // Probe leaving the end of the chosen row
  probe_t               tail;
  logic                 tail_act;
  status_e              tail_status;
  logic [CountBits-1:0] tail_count;
  logic [FillBits-1:0]  fill_cur, fill_new;
  logic [FillBits+4:0]  fill_ext;

  assign tail     = chain_probe[cur_t_q][ENTRIES_PER_TABLE];
  assign tail_act = tail.active;
  assign fill_cur = fill_q[cur_t_q];

  always_comb begin
    if (tail.done) begin
      tail_status = tail.status;
      tail_count  = tail.count;
    end else begin
      // no match and no free slot seen along the row
      tail_status = (tail.add && (tail.amount != '0)) ? StFull : StNoMatch;
      tail_count  = '0;
    end
    fill_new = fill_cur;
    if (tail_status == StNew) begin
      fill_new = fill_cur + FillBits'(1);
    end else if (tail_status == StEvicted) begin
      fill_new = fill_cur - FillBits'(1);
    end
  end

  assign fill_ext = {5'b0, fill_new};

  // Launch a probe into the chosen row; clear and bad category answer at once
  always_comb begin
    for (int t = 0; t < TABLES; t++) begin
      inj_d[t]        = '0;
      inj_d[t].amount = amount_i;
      inj_d[t].add    = (cmd == CmdAdd);
      if (in_accept && (cmd != CmdClear) && tbl_ok && (TIdxBits'(t) == tsel)) begin
        inj_d[t].active = 1'b1;
      end
      if (cmd == CmdNone) begin
        // unknown command: already settled, just fetch the fill at the end
        inj_d[t].done   = 1'b1;
        inj_d[t].status = StNoMatch;
      end
    end
  end

  assign out_load = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d        = busy_q;
    pend_valid_d  = pend_valid_q;
    pend_status_d = pend_status_q;
    pend_count_d  = pend_count_q;
    pend_fill_d   = pend_fill_q;
    if (out_load) begin
      pend_valid_d = 1'b0;
      busy_d       = 1'b0;
    end
    if (in_accept) begin
      busy_d = 1'b1;
      if (cmd == CmdClear) begin
        pend_valid_d  = 1'b1;
        pend_status_d = StChanged;
        pend_count_d  = '0;
        pend_fill_d   = '0;
      end else if (!tbl_ok) begin
        pend_valid_d  = 1'b1;
        pend_status_d = StNoMatch;
        pend_count_d  = '0;
        pend_fill_d   = '0;
      end
    end
    if (tail_act) begin
      pend_valid_d  = 1'b1;
      pend_status_d = tail_status;
      pend_count_d  = tail_count;
      pend_fill_d   = fill_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_t_q      <= '0;
      for (int t = 0; t < TABLES; t++) begin
        inj_q[t]  <= '0;
        fill_q[t] <= '0;
      end
    end else begin
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        cur_t_q <= tsel;
      end
      for (int t = 0; t < TABLES; t++) begin
        inj_q[t] <= inj_d[t];
        if (clr) begin
          fill_q[t] <= '0;
        end else if (tail_act && (TIdxBits'(t) == cur_t_q)) begin
          fill_q[t] <= fill_new;
        end
      end
    end
  end

  // Payload registers: hold until replaced
  always_ff @(posedge clk_i) begin
    inj_key_q     <= key_in;
    pend_status_q <= pend_status_d;
    pend_count_q  <= pend_count_d;
    pend_fill_q   <= pend_fill_d;
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_count_q  <= pend_count_q;
      out_fill_q   <= pend_fill_q;
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign new_count_o = out_count_q;
  assign fill_o      = out_fill_q;

  // A probe only reaches the row end for a command still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_act |-> busy_q)
    else $error("probe left a row with no command in flight");

  // A result never lands on an undelivered one
  assert property (@(posedge clk_i) disable iff (!rst_ni) tail_act |-> !pend_valid_q)
    else $error("row result overwrote a pending result");

  // Every beat taken keeps the block busy until its result moves out
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> busy_q)
    else $error("busy dropped right after an input beat");

  // Fill of the table in use never passes the row length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_cur) <= ENTRIES_PER_TABLE)
    else $error("table fill beyond row length");

endmodule
